@@ hw/rtl/gsi_pkg.sv @@
// ----------------------------------------------------------------------------
// gsi_pkg - shared types and constants of the gain schedule interpolator
// Table geometry, fixed-point widths, command codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gsi_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int FRAC_BITS   = 16;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 4;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int DIFF_W      = WORD_W + 1;
   localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);
   localparam int MIN_COUNT   = 2;

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // region codes
   localparam logic [1:0] REGION_INTERIOR = 2'd0;
   localparam logic [1:0] REGION_FIRST    = 2'd1;
   localparam logic [1:0] REGION_LAST     = 2'd2;

   // gain slots, in output order
   localparam logic [1:0] GAIN_KC = 2'd0;
   localparam logic [1:0] GAIN_TI = 2'd1;
   localparam logic [1:0] GAIN_TD = 2'd2;

   typedef struct packed {
      logic signed [WORD_W-1:0] td;
      logic signed [WORD_W-1:0] ti;
      logic signed [WORD_W-1:0] kc;
      logic signed [WORD_W-1:0] pos;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_FIRST,
      ST_CHECK_FIRST,
      ST_CHECK_LAST,
      ST_SEARCH,
      ST_PROBE,
      ST_DIV_SETUP,
      ST_DIVIDE,
      ST_SUB,
      ST_MUL,
      ST_ADD,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID
   } rd_sel_type;

   typedef struct packed {
      logic       write_row;
      logic       cap_lookup;
      rd_sel_type rd_sel;
      logic       take_first;
      logic       take_last;
      logic       take_probe;
      logic       clamp_first;
      logic       clamp_last;
      logic       div_setup;
      logic       div_step;
      logic       lerp_sub;
      logic       lerp_mul;
      logic       lerp_add;
   } ctrl_cmd_type;

   typedef struct packed {
      logic z_le_rd;     // z <= position of the row just read
      logic z_lt_rd;     // z <  position of the row just read
      logic span_wide;   // hi - lo > 1
      logic div_done;    // last quotient bit this cycle
      logic gain_done;   // last gain written this cycle
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/gsi_ram.sv @@
// ----------------------------------------------------------------------------
// gsi_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// gsi_ctrl - sequencer of the gain schedule interpolator
// Steps a lookup through clamp checks and, unless clamped, binary search, division
// and the three interpolations; row writes complete on the transfer edge.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_cmd,
   input  wire gsi_pkg::dp_status_type status,
   output gsi_pkg::ctrl_cmd_type       ctrl,
   output logic                        busy,
   output logic                        rsp_valid
);

   import gsi_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_LOOKUP) begin
               state_in = ST_READ_FIRST;
            end
         end
         ST_READ_FIRST:  state_in = ST_CHECK_FIRST;
         ST_CHECK_FIRST: state_in = status.z_le_rd ? ST_RESP : ST_CHECK_LAST;
         ST_CHECK_LAST:  state_in = status.z_lt_rd ? ST_SEARCH : ST_RESP;
         ST_SEARCH:      state_in = status.span_wide ? ST_PROBE : ST_DIV_SETUP;
         ST_PROBE:       state_in = ST_SEARCH;
         ST_DIV_SETUP:   state_in = ST_DIVIDE;
         ST_DIVIDE:      state_in = status.div_done ? ST_SUB : ST_DIVIDE;
         ST_SUB:         state_in = ST_MUL;
         ST_MUL:         state_in = ST_ADD;
         ST_ADD:         state_in = status.gain_done ? ST_RESP : ST_SUB;
         ST_RESP:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl      = '0;
      ctrl.rd_sel = RD_FIRST;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            ctrl.write_row  = accept && (req_cmd == CMD_WRITE);
            ctrl.cap_lookup = accept && (req_cmd == CMD_LOOKUP);
         end
         ST_READ_FIRST: ctrl.rd_sel = RD_FIRST;
         ST_CHECK_FIRST: begin
            ctrl.rd_sel      = RD_LAST;
            ctrl.clamp_first = status.z_le_rd;
            ctrl.take_first  = !status.z_le_rd;
         end
         ST_CHECK_LAST: begin
            ctrl.rd_sel     = RD_MID;
            ctrl.clamp_last = !status.z_lt_rd;
            ctrl.take_last  = status.z_lt_rd;
         end
         ST_SEARCH:    ctrl.rd_sel     = RD_MID;
         ST_PROBE:     ctrl.take_probe = 1'b1;
         ST_DIV_SETUP: ctrl.div_setup  = 1'b1;
         ST_DIVIDE:    ctrl.div_step   = 1'b1;
         ST_SUB:       ctrl.lerp_sub   = 1'b1;
         ST_MUL:       ctrl.lerp_mul   = 1'b1;
         ST_ADD:       ctrl.lerp_add   = 1'b1;
         ST_RESP:      rsp_valid       = 1'b1;
         default:      busy            = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/gsi_datapath.sv @@
// ----------------------------------------------------------------------------
// gsi_datapath - table, search, divider and interpolator of the block
// Row RAM, bracket registers, restoring divider for the fraction and one
// shared multiplier stepped over the three gains.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gsi_pkg::ctrl_cmd_type          ctrl,
   output gsi_pkg::dp_status_type              status,
   input  wire logic [gsi_pkg::COUNT_W-1:0]    csr_wr_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [gsi_pkg::INDEX_W-1:0]    req_entry_index,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_z_value,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_kc_in,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_ti_in,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_td_in,
   output logic signed [gsi_pkg::WORD_W-1:0]   rsp_kc_out,
   output logic signed [gsi_pkg::WORD_W-1:0]   rsp_ti_out,
   output logic signed [gsi_pkg::WORD_W-1:0]   rsp_td_out,
   output logic [1:0]                          rsp_region,
   output logic [gsi_pkg::INDEX_W-1:0]         rsp_lower_row
);

   import gsi_pkg::*;

   function automatic logic signed [WORD_W-1:0] pick_gain(row_type r, logic [1:0] g);
      logic signed [WORD_W-1:0] v;
      unique case (g)
         GAIN_KC: v = r.kc;
         GAIN_TI: v = r.ti;
         GAIN_TD: v = r.td;
         default: v = r.kc;
      endcase
      return v;
   endfunction

   // configuration
   logic [COUNT_W-1:0] count_ff;
   logic [IDX_W-1:0]   last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(MIN_COUNT);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (int'(count_ff) < MIN_COUNT) begin
         last_in = IDX_W'(MIN_COUNT - 1);
      end else if (int'(count_ff) > MAX_ENTRIES) begin
         last_in = IDX_W'(MAX_ENTRIES - 1);
      end else begin
         last_in = IDX_W'(count_ff - COUNT_W'(1));
      end
   end

   // row memory
   row_type          wr_row;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ROW_W-1:0] rd_raw;
   row_type          rd_row;

   logic [IDX_W-1:0] lo_ff, hi_ff, last_ff;
   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;

   assign wr_row = '{td: req_td_in, ti: req_ti_in, kc: req_kc_in, pos: req_z_value};
   assign wr_en  = ctrl.write_row && (int'(req_entry_index) < MAX_ENTRIES);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      unique case (ctrl.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = last_ff;
         RD_MID:   rd_addr = mid;
         default:  rd_addr = '0;
      endcase
   end

   gsi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ENTRIES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (ROW_W'(wr_row)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_row = row_type'(rd_raw);

   // bracket search
   logic signed [WORD_W-1:0] z_ff;
   row_type                  lo_row_ff, hi_row_ff;

   always_ff @(posedge clock) begin
      if (ctrl.cap_lookup) begin
         z_ff    <= req_z_value;
         last_ff <= last_in;
         lo_ff   <= '0;
         hi_ff   <= last_in;
      end
      if (ctrl.take_first) begin
         lo_row_ff <= rd_row;
      end
      if (ctrl.take_last) begin
         hi_row_ff <= rd_row;
      end
      if (ctrl.take_probe) begin
         if (z_ff < rd_row.pos) begin
            hi_ff     <= mid;
            hi_row_ff <= rd_row;
         end else begin
            lo_ff     <= mid;
            lo_row_ff <= rd_row;
         end
      end
   end

   // fraction: restoring division, one quotient bit per cycle
   logic [WORD_W-1:0]    rem_ff, den_ff;
   logic [FRAC_BITS-1:0] quot_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [WORD_W:0]      rem_shift;
   logic                 rem_ge;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (ctrl.div_setup) begin
         rem_ff     <= WORD_W'(z_ff - lo_row_ff.pos);
         den_ff     <= WORD_W'(hi_row_ff.pos - lo_row_ff.pos);
         div_cnt_ff <= '0;
      end else if (ctrl.div_step) begin
         rem_ff     <= rem_ge ? WORD_W'(rem_shift - {1'b0, den_ff}) : WORD_W'(rem_shift);
         quot_ff    <= {quot_ff[FRAC_BITS-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // interpolation, one gain at a time through one multiplier
   logic [1:0]               gain_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [WORD_W-1:0] base_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WORD_W-1:0] lerp_out;
   logic signed [WORD_W-1:0] kc_ff, ti_ff, td_ff;
   logic [1:0]               region_ff;
   logic [IDX_W-1:0]         lower_ff;

   assign lerp_out = base_ff + prod_ff[FRAC_BITS +: WORD_W];

   always_ff @(posedge clock) begin
      if (ctrl.div_setup) begin
         gain_ff <= GAIN_KC;
      end
      if (ctrl.lerp_sub) begin
         diff_ff <= DIFF_W'(pick_gain(hi_row_ff, gain_ff))
                  - DIFF_W'(pick_gain(lo_row_ff, gain_ff));
         base_ff <= pick_gain(lo_row_ff, gain_ff);
      end
      if (ctrl.lerp_mul) begin
         prod_ff <= diff_ff * $signed({1'b0, quot_ff});
      end
      if (ctrl.lerp_add) begin
         unique case (gain_ff)
            GAIN_KC: kc_ff <= lerp_out;
            GAIN_TI: ti_ff <= lerp_out;
            default: td_ff <= lerp_out;
         endcase
         gain_ff   <= gain_ff + 2'd1;
         region_ff <= REGION_INTERIOR;
         lower_ff  <= lo_ff;
      end
      if (ctrl.clamp_first || ctrl.clamp_last) begin
         kc_ff     <= rd_row.kc;
         ti_ff     <= rd_row.ti;
         td_ff     <= rd_row.td;
         region_ff <= ctrl.clamp_first ? REGION_FIRST : REGION_LAST;
         lower_ff  <= ctrl.clamp_first ? '0 : last_ff;
      end
   end

   assign status.z_le_rd   = z_ff <= rd_row.pos;
   assign status.z_lt_rd   = z_ff < rd_row.pos;
   assign status.span_wide = (hi_ff - lo_ff) > IDX_W'(1);
   assign status.div_done  = int'(div_cnt_ff) == FRAC_BITS - 1;
   assign status.gain_done = gain_ff == GAIN_TD;

   assign rsp_kc_out    = kc_ff;
   assign rsp_ti_out    = ti_ff;
   assign rsp_td_out    = td_ff;
   assign rsp_region    = region_ff;
   assign rsp_lower_row = INDEX_W'(lower_ff);

endmodule

`default_nettype wire

@@ hw/rtl/gain_schedule_interpolator.sv @@
// Sequence: a row write completes on its transfer edge and leaves busy low.
// A lookup checks the first row and, unless clamped there, the last row,
// strobing its result when clamped; else it binary-searches through the single
// RAM read port, divides for 16 fraction bits and does a subtract, multiply and
// add per gain on one multiplier; next request is taken the cycle after the strobe.
// Reset: synchronous, active high; entry_count returns to 2, table contents kept.
// ----------------------------------------------------------------------------
// gain_schedule_interpolator - piecewise linear gain schedule lookup
// Breakpoint table of rows (position, kc, ti, td); a lookup clamps to the end
// rows or binary-searches the bracket and interpolates the three gains.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_schedule_interpolator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [gsi_pkg::COUNT_W-1:0]       csr_wr_data,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_cmd,
   input  wire logic [gsi_pkg::INDEX_W-1:0]       req_entry_index,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_z_value,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_kc_in,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_ti_in,
   input  wire logic signed [gsi_pkg::WORD_W-1:0] req_td_in,
   // result channel, one strobed cycle per lookup
   output logic                                   rsp_valid,
   output logic signed [gsi_pkg::WORD_W-1:0]      rsp_kc_out,
   output logic signed [gsi_pkg::WORD_W-1:0]      rsp_ti_out,
   output logic signed [gsi_pkg::WORD_W-1:0]      rsp_td_out,
   output logic [1:0]                             rsp_region,
   output logic [gsi_pkg::INDEX_W-1:0]            rsp_lower_row
);

   import gsi_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   // Sequencer: owns the only state that reset clears besides the row count.
   gsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: row RAM, bracket registers, divider, shared multiplier and
   // the result registers, which keep their values until the next lookup writes them.
   gsi_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .csr_wr_data     (csr_wr_data),
      .csr_wr_en       (csr_wr_en),
      .req_entry_index (req_entry_index),
      .req_z_value     (req_z_value),
      .req_kc_in       (req_kc_in),
      .req_ti_in       (req_ti_in),
      .req_td_in       (req_td_in),
      .rsp_kc_out      (rsp_kc_out),
      .rsp_ti_out      (rsp_ti_out),
      .rsp_td_out      (rsp_td_out),
      .rsp_region      (rsp_region),
      .rsp_lower_row   (rsp_lower_row)
   );

endmodule

`default_nettype wire

@@ hw/rtl/gsi_checker.sv @@
// ----------------------------------------------------------------------------
// gsi_checker - port-level checks of the gain schedule interpolator
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_cmd,
   input wire logic                         rsp_valid,
   input wire logic [1:0]                   rsp_region,
   input wire logic [gsi_pkg::INDEX_W-1:0]  rsp_lower_row
);

   import gsi_pkg::*;

   // a lookup transfer makes the block busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_LOOKUP) |=> busy)
      else $error("lookup transfer did not raise busy");

   // a row write never ties the block up
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_WRITE) |=> !busy && !rsp_valid)
      else $error("row write raised busy or a result");

   // result strobe is one cycle and frees the block
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle or block still busy");

   // region code is legal, and a first-row clamp reports row zero
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region == REGION_INTERIOR || rsp_region == REGION_FIRST
                     || rsp_region == REGION_LAST))
      else $error("illegal region code");

   a_first_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_region == REGION_FIRST) |-> rsp_lower_row == '0)
      else $error("first-row clamp with non-zero lower row");

endmodule

bind gain_schedule_interpolator gsi_checker u_gsi_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_region    (rsp_region),
   .rsp_lower_row (rsp_lower_row)
);

`default_nettype wire
